[rtl/pct_pkg.sv]
// Package with the command codes and count constants of the prefix count trie.
`default_nettype none
package pct_pkg;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned CNT_W    = 24;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  localparam logic [CNT_W-1:0] COUNT_MAX = 24'hFFFFFF;
endpackage
`default_nettype wire

[rtl/pct_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module pct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[rtl/prefix_count_trie_top.sv]
// Top level of the prefix count trie: letter sequencer and node pool memories.
`default_nettype none
// Words arrive one letter per item; an item is taken when start is high and busy is low.
// An insert letter does a child lookup, then an allocation or a count update; a query
// letter does the lookup alone and a delete letter is only buffered. The final letter
// of an insert or query adds the count read and the result, or only the result when
// the word was broken or empty. A delete word then walks its buffered letters through
// the child memory twice: lookups and a count read, then lookups with count updates
// and a cut of the end node's children. The single read port of each pool memory sets
// these steps. A result is shown for one cycle on done_o and cannot be held off; the
// block raises busy until it is out.
module prefix_count_trie_top #(
  parameter int unsigned NODES    = 4096,
  parameter int unsigned ALPHABET = 26,
  parameter int unsigned MAX_LEN  = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command_i,
  input  wire logic [4:0]  letter_i,
  input  wire logic        last_i,
  output logic             done_o,
  output logic [1:0]       done_command_o,
  output logic             matched_o,
  output logic [23:0]      prefix_count_o,
  output logic             pool_full_o,
  output logic             word_too_long_o
);
  localparam int unsigned NW  = $clog2(NODES);
  localparam int unsigned LTW = $clog2(ALPHABET);
  localparam int unsigned CAW = $clog2(NODES * ALPHABET);
  localparam int unsigned LW  = $clog2(MAX_LEN + 1);
  localparam int unsigned BW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_LOOK, S_ALLOC, S_INC_RD, S_INC, S_END, S_FIN,
    S_W_BUF, S_W_LET, S_W_ISS, S_W_LOOK, S_W_CRD, S_W_CNT, S_S_RD, S_S_SUB,
    S_CUT, S_OUT
  } state_e;

  state_e                  state_q;
  logic                    active_q, broken_q, pool_q, long_q, last_q, phase_q;
  logic [pct_pkg::CMD_W-1:0] cmd_q;
  logic [LTW-1:0]          let_q;
  logic [NW-1:0]           cur_q;
  logic [NW:0]             nf_q;
  logic [LW-1:0]           len_q, i_q;
  logic [pct_pkg::CNT_W-1:0] cnt_q;
  logic [ALPHABET-1:0]     root_q;

  logic                    accept, ltr_ok, len_full, node_valid, walk_end;
  logic [pct_pkg::CMD_W-1:0] eff_cmd;
  logic [ALPHABET-1:0]     node_row;
  logic [CAW-1:0]          ci_addr;
  logic [LW-1:0]           i_inc;

  logic                    cv_we, ci_we, cnt_we, wb_we;
  logic [ALPHABET-1:0]     cv_wdata, cv_rdata;
  logic [NW-1:0]           ci_rdata;
  logic [pct_pkg::CNT_W-1:0] cnt_wdata, cnt_rdata;
  logic [LTW-1:0]          wb_rdata;

  assign busy       = (state_q != S_IDLE);
  assign accept     = start && !busy;
  assign eff_cmd    = active_q ? cmd_q : command_i;
  assign ltr_ok     = 7'(letter_i) < 7'(ALPHABET);
  assign len_full   = len_q >= LW'(MAX_LEN);
  assign node_row   = (cur_q == '0) ? root_q : cv_rdata;
  assign node_valid = node_row[let_q];
  assign ci_addr    = CAW'(cur_q) * CAW'(ALPHABET) + CAW'(let_q);
  assign i_inc      = i_q + LW'(1);
  assign walk_end   = (i_inc == len_q);

  always_comb begin
    cv_we     = 1'b0;
    cv_wdata  = '0;
    ci_we     = 1'b0;
    cnt_we    = 1'b0;
    cnt_wdata = '0;
    wb_we     = accept && !(!active_q && command_i == pct_pkg::CMD_NONE) && !broken_q
                && !len_full && ltr_ok && eff_cmd == pct_pkg::CMD_DELETE;
    unique case (state_q)
      S_LOOK: begin
        if (!node_valid && cmd_q == pct_pkg::CMD_INSERT && nf_q < (NW+1)'(NODES)) begin
          ci_we    = 1'b1;
          cv_we    = (cur_q != '0);
          cv_wdata = cv_rdata | (ALPHABET'(1) << let_q);
        end
      end
      S_ALLOC: begin
        cv_we     = 1'b1;
        cnt_we    = 1'b1;
        cnt_wdata = pct_pkg::CNT_W'(1);
      end
      S_INC: begin
        cnt_we    = 1'b1;
        cnt_wdata = (cnt_rdata == pct_pkg::COUNT_MAX) ? cnt_rdata
                                                      : cnt_rdata + pct_pkg::CNT_W'(1);
      end
      S_S_SUB: begin
        cnt_we    = 1'b1;
        cnt_wdata = (cnt_rdata > cnt_q) ? cnt_rdata - cnt_q : '0;
      end
      S_CUT: begin
        cv_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  pct_ram #(.WIDTH(NW), .DEPTH(NODES * ALPHABET)) u_child_index (
    .clk_i(clk_i), .we_i(ci_we), .waddr_i(ci_addr), .wdata_i(nf_q[NW-1:0]),
    .raddr_i(ci_addr), .rdata_o(ci_rdata)
  );

  pct_ram #(.WIDTH(ALPHABET), .DEPTH(NODES)) u_child_valid (
    .clk_i(clk_i), .we_i(cv_we), .waddr_i(cur_q), .wdata_i(cv_wdata),
    .raddr_i(cur_q), .rdata_o(cv_rdata)
  );

  pct_ram #(.WIDTH(pct_pkg::CNT_W), .DEPTH(NODES)) u_node_count (
    .clk_i(clk_i), .we_i(cnt_we), .waddr_i(cur_q), .wdata_i(cnt_wdata),
    .raddr_i(cur_q), .rdata_o(cnt_rdata)
  );

  pct_ram #(.WIDTH(LTW), .DEPTH(MAX_LEN)) u_word_buffer (
    .clk_i(clk_i), .we_i(wb_we), .waddr_i(len_q[BW-1:0]), .wdata_i(LTW'(letter_i)),
    .raddr_i(i_q[BW-1:0]), .rdata_o(wb_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      active_q        <= 1'b0;
      broken_q        <= 1'b0;
      pool_q          <= 1'b0;
      long_q          <= 1'b0;
      last_q          <= 1'b0;
      phase_q         <= 1'b0;
      cmd_q           <= pct_pkg::CMD_INSERT;
      let_q           <= '0;
      cur_q           <= '0;
      nf_q            <= (NW+1)'(1);
      len_q           <= '0;
      i_q             <= '0;
      cnt_q           <= '0;
      root_q          <= '0;
      done_o          <= 1'b0;
      done_command_o  <= '0;
      matched_o       <= 1'b0;
      prefix_count_o  <= '0;
      pool_full_o     <= 1'b0;
      word_too_long_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept && !(!active_q && command_i == pct_pkg::CMD_NONE)) begin
            active_q <= 1'b1;
            cmd_q    <= eff_cmd;
            last_q   <= last_i;
            let_q    <= LTW'(letter_i);
            state_q  <= last_i ? S_END : S_IDLE;
            if (!broken_q) begin
              if (len_full) begin
                long_q   <= 1'b1;
                broken_q <= 1'b1;
              end else if (!ltr_ok) begin
                broken_q <= 1'b1;
              end else if (eff_cmd == pct_pkg::CMD_DELETE) begin
                len_q <= len_q + LW'(1);
              end else begin
                state_q <= S_RD;
              end
            end
          end
        end
        S_RD: begin
          state_q <= S_LOOK;
        end
        S_LOOK: begin
          if (node_valid) begin
            cur_q <= ci_rdata;
            if (cmd_q == pct_pkg::CMD_INSERT) begin
              state_q <= S_INC_RD;
            end else begin
              len_q   <= len_q + LW'(1);
              state_q <= last_q ? S_END : S_IDLE;
            end
          end else if (cmd_q == pct_pkg::CMD_INSERT && nf_q < (NW+1)'(NODES)) begin
            if (cur_q == '0) begin
              root_q[let_q] <= 1'b1;
            end
            cur_q   <= nf_q[NW-1:0];
            nf_q    <= nf_q + (NW+1)'(1);
            state_q <= S_ALLOC;
          end else begin
            pool_q   <= (cmd_q == pct_pkg::CMD_INSERT);
            broken_q <= 1'b1;
            state_q  <= last_q ? S_END : S_IDLE;
          end
        end
        S_ALLOC, S_INC: begin
          len_q   <= len_q + LW'(1);
          state_q <= last_q ? S_END : S_IDLE;
        end
        S_INC_RD: begin
          state_q <= S_INC;
        end
        S_END: begin
          cnt_q <= '0;
          if (broken_q || len_q == '0) begin
            state_q <= S_OUT;
          end else if (cmd_q == pct_pkg::CMD_DELETE) begin
            i_q     <= '0;
            cur_q   <= '0;
            phase_q <= 1'b0;
            state_q <= S_W_BUF;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          cnt_q   <= cnt_rdata;
          state_q <= S_OUT;
        end
        S_W_BUF: begin
          state_q <= S_W_LET;
        end
        S_W_LET: begin
          let_q   <= wb_rdata;
          state_q <= S_W_ISS;
        end
        S_W_ISS: begin
          state_q <= S_W_LOOK;
        end
        S_W_LOOK: begin
          if (!phase_q) begin
            if (!node_valid) begin
              state_q <= S_OUT;
            end else begin
              cur_q   <= ci_rdata;
              i_q     <= i_inc;
              state_q <= walk_end ? S_W_CRD : S_W_BUF;
            end
          end else begin
            cur_q   <= ci_rdata;
            state_q <= S_S_RD;
          end
        end
        S_W_CRD: begin
          state_q <= S_W_CNT;
        end
        S_W_CNT: begin
          cnt_q <= cnt_rdata;
          if (cnt_rdata == '0) begin
            state_q <= S_OUT;
          end else begin
            phase_q <= 1'b1;
            i_q     <= '0;
            cur_q   <= '0;
            state_q <= S_W_BUF;
          end
        end
        S_S_RD: begin
          state_q <= S_S_SUB;
        end
        S_S_SUB: begin
          i_q     <= i_inc;
          state_q <= walk_end ? S_CUT : S_W_BUF;
        end
        S_CUT: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          done_o          <= 1'b1;
          done_command_o  <= cmd_q;
          matched_o       <= (cnt_q != '0);
          prefix_count_o  <= cnt_q;
          pool_full_o     <= (cmd_q == pct_pkg::CMD_INSERT) && pool_q;
          word_too_long_o <= long_q;
          active_q        <= 1'b0;
          broken_q        <= 1'b0;
          pool_q          <= 1'b0;
          long_q          <= 1'b0;
          cur_q           <= '0;
          len_q           <= '0;
          state_q         <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("Result strobe held for more than one cycle.");
  a_matched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (matched_o == (prefix_count_o != '0)))
    else $error("Matched flag disagrees with the count.");
  a_pool_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && pool_full_o |-> done_command_o == pct_pkg::CMD_INSERT && !matched_o)
    else $error("Pool flag on a word that is not a failed insert.");
  a_long_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && word_too_long_o |-> prefix_count_o == '0)
    else $error("Overlong word reported a nonzero count.");
  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nf_q <= (NW+1)'(NODES) && nf_q != '0) else $error("Free node pointer out of range.");
`endif
endmodule
`default_nettype wire

[bench/tb_prefix_count_trie_top.sv]
// Self-checking testbench for the prefix count trie: directed words and random words.
`default_nettype none
module tb_prefix_count_trie_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NODES    = 4096;
  localparam int unsigned ALPHABET = 26;
  localparam int unsigned MAX_LEN  = 32;

  typedef struct packed {
    logic [pct_pkg::CMD_W-1:0] cmd;
    logic                      matched;
    logic [pct_pkg::CNT_W-1:0] count;
    logic                      pool_full;
    logic                      too_long;
  } trie_result_t;

  typedef struct packed {
    logic [pct_pkg::CMD_W-1:0]    cmd;
    logic [pct_pkg::LETTER_W-1:0] letter;
    logic                         last;
    logic                         typed;
    trie_result_t                 answer;
  } letter_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [pct_pkg::CMD_W-1:0]    command_i = pct_pkg::CMD_INSERT;
  logic [pct_pkg::LETTER_W-1:0] letter_i = '0;
  logic                         last_i = 1'b0;
  logic                         done_o;
  logic [pct_pkg::CMD_W-1:0]    done_command_o;
  logic                         matched_o;
  logic [pct_pkg::CNT_W-1:0]    prefix_count_o;
  logic                         pool_full_o;
  logic                         word_too_long_o;

  prefix_count_trie_top dut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .letter_i, .last_i, .done_o,
    .done_command_o, .matched_o, .prefix_count_o, .pool_full_o, .word_too_long_o
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("prefix_count_trie_top verification failed");
    $finish;
  end

  // Predictor state of the trie.
  logic [11:0]                  kid_node [NODES*ALPHABET];
  logic [25:0]                  kid_valid [NODES];
  logic [pct_pkg::CNT_W-1:0]    pass_count [NODES];
  int unsigned                  free_node;
  int unsigned                  cur_node;
  bit                           broken;
  logic [pct_pkg::LETTER_W-1:0] del_letters [MAX_LEN];
  int unsigned                  word_len;
  bit                           in_word;
  logic [pct_pkg::CMD_W-1:0]    word_cmd;
  bit                           hit_pool;
  bit                           hit_long;

  trie_result_t expected_results[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int pool_full_seen = 0;
  int too_long_seen = 0;
  int deletes_seen = 0;

  function automatic bit follow(input int unsigned n,
                                input logic [pct_pkg::LETTER_W-1:0] c,
                                output int unsigned to);
    to = 0;
    if (c >= ALPHABET) return 1'b0;
    if (!kid_valid[n][c]) return 1'b0;
    to = kid_node[n*ALPHABET + c];
    return 1'b1;
  endfunction

  function automatic void clear_trie();
    foreach (kid_valid[i]) kid_valid[i] = '0;
    foreach (pass_count[i]) pass_count[i] = '0;
    free_node = 1;
    cur_node = 0;
    broken = 0;
    word_len = 0;
    in_word = 0;
    hit_pool = 0;
    hit_long = 0;
  endfunction

  function automatic bit trie_letter(input logic [pct_pkg::CMD_W-1:0] cmd,
                                     input logic [pct_pkg::LETTER_W-1:0] c,
                                     input logic last, output trie_result_t r);
    int unsigned p;
    logic [pct_pkg::CNT_W-1:0] v;
    bit ok;
    r = '0;
    v = '0;
    if (!in_word) begin
      if (cmd == pct_pkg::CMD_NONE) return 1'b0;
      in_word = 1;
      word_cmd = cmd;
    end
    if (!broken) begin
      if (word_len >= MAX_LEN) begin
        hit_long = 1;
        broken = 1;
      end else if (c >= ALPHABET) begin
        broken = 1;
      end else if (word_cmd == pct_pkg::CMD_INSERT) begin
        if (!follow(cur_node, c, p)) begin
          if (free_node < NODES) begin
            p = free_node++;
            kid_node[cur_node*ALPHABET + c] = p;
            kid_valid[cur_node][c] = 1'b1;
            kid_valid[p] = '0;
            pass_count[p] = '0;
          end else begin
            hit_pool = 1;
            broken = 1;
          end
        end
        if (!broken) begin
          if (pass_count[p] != pct_pkg::COUNT_MAX) pass_count[p]++;
          cur_node = p;
          word_len++;
        end
      end else if (word_cmd == pct_pkg::CMD_DELETE) begin
        del_letters[word_len] = c;
        word_len++;
      end else begin
        if (follow(cur_node, c, p)) begin
          cur_node = p;
          word_len++;
        end else begin
          broken = 1;
        end
      end
    end
    if (!last) return 1'b0;
    if (word_cmd != pct_pkg::CMD_DELETE) begin
      if (!broken && word_len > 0) v = pass_count[cur_node];
    end else if (!broken && word_len > 0) begin
      ok = 1;
      p = 0;
      for (int i = 0; i < word_len; i++) begin
        if (!follow(p, del_letters[i], p)) begin
          ok = 0;
          break;
        end
      end
      if (ok) v = pass_count[p];
      if (ok && v != 0) begin
        p = 0;
        for (int i = 0; i < word_len; i++) begin
          if (!follow(p, del_letters[i], p)) break;
          pass_count[p] = pass_count[p] > v ? pass_count[p] - v : '0;
        end
        kid_valid[p] = '0;
      end
    end
    r.cmd = word_cmd;
    r.matched = (v != 0);
    r.count = v;
    r.pool_full = (word_cmd == pct_pkg::CMD_INSERT) && hit_pool;
    r.too_long = hit_long;
    in_word = 0;
    cur_node = 0;
    broken = 0;
    word_len = 0;
    hit_pool = 0;
    hit_long = 0;
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result with none expected: cmd %0d count %0d", done_command_o,
               prefix_count_o);
        errors++;
      end else begin
        trie_result_t e;
        e = expected_results.pop_front();
        results_seen++;
        if (done_command_o !== e.cmd) begin
          $error("done_command expected %0d actual %0d", e.cmd, done_command_o);
          errors++;
        end
        if (matched_o !== e.matched) begin
          $error("matched expected %0d actual %0d", e.matched, matched_o);
          errors++;
        end
        if (prefix_count_o !== e.count) begin
          $error("prefix_count expected %0d actual %0d", e.count, prefix_count_o);
          errors++;
        end
        if (pool_full_o !== e.pool_full) begin
          $error("pool_full expected %0d actual %0d", e.pool_full, pool_full_o);
          errors++;
        end
        if (word_too_long_o !== e.too_long) begin
          $error("word_too_long expected %0d actual %0d", e.too_long, word_too_long_o);
          errors++;
        end
      end
    end
  end

  int gap_pct = 0;

  task automatic send_letter(input letter_row_t row);
    trie_result_t r;
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    command_i <= row.cmd;
    letter_i <= row.letter;
    last_i <= row.last;
    do @(posedge clk_i); while (busy);
    items_sent++;
    if (trie_letter(row.cmd, row.letter, row.last, r)) begin
      if (r.pool_full) pool_full_seen++;
      if (r.too_long) too_long_seen++;
      if (r.cmd == pct_pkg::CMD_DELETE) deletes_seen++;
      expected_results.push_back(row.typed ? row.answer : r);
    end
  endtask

  task automatic send_word(input logic [pct_pkg::CMD_W-1:0] cmd, input int unsigned len,
                           input int unsigned top_letter);
    letter_row_t row;
    for (int i = 0; i < len; i++) begin
      row = '0;
      row.cmd = (i == 0) ? cmd : pct_pkg::CMD_W'($urandom_range(3));
      row.letter = pct_pkg::LETTER_W'($urandom_range(top_letter));
      row.last = (i == len - 1);
      send_letter(row);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic letter_row_t make_row(input logic [pct_pkg::CMD_W-1:0] cmd,
                                           input int letter, input bit last,
                                           input bit typed, input int count);
    letter_row_t row;
    row.cmd = cmd;
    row.letter = pct_pkg::LETTER_W'(letter);
    row.last = last;
    row.typed = typed;
    row.answer.cmd = cmd;
    row.answer.matched = (count != 0);
    row.answer.count = pct_pkg::CNT_W'(count);
    row.answer.pool_full = 1'b0;
    row.answer.too_long = 1'b0;
    return row;
  endfunction

  task automatic random_words(input int unsigned letters);
    int unsigned goal;
    int unsigned pick;
    logic [pct_pkg::CMD_W-1:0] cmd;
    goal = items_sent + letters;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      cmd = pick < 45 ? pct_pkg::CMD_INSERT : pick < 75 ? pct_pkg::CMD_QUERY :
            pick < 93 ? pct_pkg::CMD_DELETE : pct_pkg::CMD_NONE;
      pick = $urandom_range(99);
      if (pick < 80) send_word(cmd, $urandom_range(1, 4), 3);
      else if (pick < 93) send_word(cmd, $urandom_range(1, 8), 31);
      else send_word(cmd, $urandom_range(30, 36), 25);
    end
  endtask

  initial begin
    letter_row_t directed[$];
    clear_trie();
    directed.push_back(make_row(pct_pkg::CMD_QUERY, 0, 1, 1, 0));
    directed.push_back(make_row(pct_pkg::CMD_INSERT, 25, 1, 1, 1));
    directed.push_back(make_row(pct_pkg::CMD_INSERT, 25, 1, 1, 2));
    directed.push_back(make_row(pct_pkg::CMD_NONE, 0, 1, 0, 0));
    directed.push_back(make_row(pct_pkg::CMD_QUERY, 25, 1, 1, 2));
    directed.push_back(make_row(pct_pkg::CMD_INSERT, 25, 0, 0, 0));
    directed.push_back(make_row(pct_pkg::CMD_QUERY, 0, 1, 0, 0));
    directed.push_back(make_row(pct_pkg::CMD_QUERY, 31, 1, 1, 0));
    directed.push_back(make_row(pct_pkg::CMD_INSERT, 26, 1, 1, 0));
    directed.push_back(make_row(pct_pkg::CMD_QUERY, 25, 0, 0, 0));
    directed.push_back(make_row(pct_pkg::CMD_DELETE, 0, 1, 0, 0));
    directed.push_back(make_row(pct_pkg::CMD_DELETE, 25, 1, 0, 0));
    directed.push_back(make_row(pct_pkg::CMD_QUERY, 25, 1, 1, 0));
    directed.push_back(make_row(pct_pkg::CMD_DELETE, 7, 1, 1, 0));
    directed.push_back(make_row(pct_pkg::CMD_INSERT, 0, 0, 0, 0));
    directed.push_back(make_row(pct_pkg::CMD_NONE, 1, 1, 0, 0));
    directed.push_back(make_row(pct_pkg::CMD_QUERY, 0, 0, 0, 0));
    directed.push_back(make_row(pct_pkg::CMD_INSERT, 1, 1, 0, 0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_letter(directed[i]);
    send_word(pct_pkg::CMD_INSERT, 33, 25);
    send_word(pct_pkg::CMD_QUERY, 34, 25);
    send_word(pct_pkg::CMD_DELETE, 33, 25);
    send_word(pct_pkg::CMD_DELETE, 32, 25);

    gap_pct = 9;
    random_words(200);
    wait_drained();
    random_words(200);
    gap_pct = 48;
    random_words(350);
    gap_pct = 0;
    random_words(350);

    start <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);

    $display("Sent %0d letters, checked %0d results (%0d deletes).", items_sent,
             results_seen, deletes_seen);
    $display("Pool exhaustion hit %0d times, overlong words %0d times.", pool_full_seen,
             too_long_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("prefix_count_trie_top verification clean");
    end else begin
      $display("prefix_count_trie_top verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

[prefix_count_trie_top.f]
rtl/pct_pkg.sv
rtl/pct_ram.sv
rtl/prefix_count_trie_top.sv
bench/tb_prefix_count_trie_top.sv
